/* rtl/assert_macros.svh */
// Assertion helpers used by the segmenter RTL.
// Each macro puts one labeled concurrent assertion on its own line.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge while reset is released.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |-> (cons), msg)

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

/* rtl/gcs_pkg.sv */
`default_nettype none

package gcs_pkg;

	localparam int unsigned IDX_W = 10;
	localparam int unsigned IN_TDATA_W = 16;
	localparam int unsigned IN_TUSER_W = 5;
	localparam int unsigned OUT_TDATA_W = 64;

	typedef logic [IDX_W-1:0] idx_t;

	// Position within one gait cycle.
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,  // waiting for an opening valley
		PH_OPEN = 2'd1,  // valley seen, waiting for the major peak
		PH_PEAK = 2'd2,  // major peak seen, collecting the near-zero run
		PH_TINY = 2'd3   // minor peak seen, waiting for the closing valley
	} phase_t;

	// Label after priority encoding of the four flags.
	typedef enum logic [2:0] {
		LBL_NONE,
		LBL_PEAK,
		LBL_TINY,
		LBL_VALLEY,
		LBL_NEAR_ZERO
	} label_t;

	// One input sample as held in the input stage.
	typedef struct packed {
		logic batch_start;
		idx_t sample_index;
		logic is_peak;
		logic is_tiny_peak;
		logic is_valley;
		logic is_near_zero;
	} item_t;

	// Running state of the cycle under construction.
	typedef struct packed {
		phase_t phase;
		idx_t   open_valley;
		idx_t   held_peak;
		idx_t   held_tiny_peak;
		idx_t   held_near_zero_first;
		idx_t   held_near_zero_last;
	} record_t;

	// One completed gait cycle.
	typedef struct packed {
		idx_t end_valley_index;
		idx_t tiny_peak_index;
		idx_t near_zero_last;
		idx_t near_zero_first;
		idx_t peak_index;
		idx_t start_valley_index;
	} result_t;

	function automatic label_t encode_label(input item_t it);
		label_t lbl;
		priority if (it.is_peak) begin
			lbl = LBL_PEAK;
		end else if (it.is_tiny_peak) begin
			lbl = LBL_TINY;
		end else if (it.is_valley) begin
			lbl = LBL_VALLEY;
		end else if (it.is_near_zero) begin
			lbl = LBL_NEAR_ZERO;
		end else begin
			lbl = LBL_NONE;
		end
		return lbl;
	endfunction

endpackage

`default_nettype wire

/* rtl/gait_cycle_segmenter.sv */
// Gait cycle segmenter. Each input transaction carries one labelled pitch
// sample: the sample index in tdata and the flags batch_start, is_peak,
// is_tiny_peak, is_valley and is_near_zero in tuser. When several label flags
// are set, peak wins over tiny peak, tiny peak over valley and valley over
// near-zero. The block follows the pattern valley, peak, near-zero run, tiny
// peak, valley and emits one output transaction for every complete cycle,
// holding the six indices of that cycle; the closing valley also opens the
// next cycle. A peak, tiny peak or valley out of order drops the cycle
// being built, and batch_start drops it before its own sample is looked at.
// Near-zero samples only count between the peak and the tiny peak, and index
// zero serves as the "none" mark in the near-zero fields. Throughput is one
// sample per clock while the output side keeps up: the sample is captured in
// an input register, the phase update and result assembly are one small
// next-state function, and the result is held in an output register. The
// input register only waits when it holds a sample while the output register
// holds a result that the downstream side has not taken yet.
`default_nettype none

`include "assert_macros.svh"

module gait_cycle_segmenter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tdata: sample_index [9:0], zero padding [15:10]
	input  wire logic [gcs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: batch_start [0], is_peak [1], is_tiny_peak [2], is_valley [3],
	// is_near_zero [4]
	input  wire logic [gcs_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// tdata: start_valley_index [9:0], peak_index [19:10],
	// near_zero_first [29:20], near_zero_last [39:30],
	// tiny_peak_index [49:40], end_valley_index [59:50], zero padding [63:60]
	output logic [gcs_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready
);
	import gcs_pkg::*;

	localparam int unsigned PAD_W = OUT_TDATA_W - $bits(result_t);

	// Input stage.
	item_t   item_s1;
	logic    valid_s1;
	// Cycle state and output register.
	record_t rec_q;
	result_t res_q;
	logic    res_valid_q;

	item_t   item_in;
	logic    s1_adv;
	label_t  label;
	record_t rec_base;
	record_t rec_d;
	result_t res_d;
	logic    emit;

	assign item_in.batch_start  = s_axis_tuser[0];
	assign item_in.sample_index = s_axis_tdata[IDX_W-1:0];
	assign item_in.is_peak      = s_axis_tuser[1];
	assign item_in.is_tiny_peak = s_axis_tuser[2];
	assign item_in.is_valley    = s_axis_tuser[3];
	assign item_in.is_near_zero = s_axis_tuser[4];

	// The held sample is processed whenever the output register can take a
	// possible result, which also frees the input register for a new sample.
	assign s1_adv        = valid_s1 && (!res_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_in;
		end
	end

	// Next-state function of the segmenter.
	always_comb begin
		label    = encode_label(item_s1);
		rec_base = item_s1.batch_start ? '0 : rec_q;
		rec_d    = rec_base;
		emit     = 1'b0;

		res_d.start_valley_index = rec_base.open_valley;
		res_d.peak_index         = rec_base.held_peak;
		res_d.near_zero_first    = rec_base.held_near_zero_first;
		res_d.near_zero_last     = rec_base.held_near_zero_last;
		res_d.tiny_peak_index    = rec_base.held_tiny_peak;
		res_d.end_valley_index   = item_s1.sample_index;

		unique case (label)
			LBL_PEAK: begin
				if (rec_base.phase == PH_OPEN) begin
					rec_d.phase     = PH_PEAK;
					rec_d.held_peak = item_s1.sample_index;
				end else begin
					rec_d = '0;
				end
			end
			LBL_TINY: begin
				if (rec_base.phase == PH_PEAK) begin
					rec_d.phase          = PH_TINY;
					rec_d.held_tiny_peak = item_s1.sample_index;
				end else begin
					rec_d = '0;
				end
			end
			LBL_VALLEY: begin
				if (rec_base.phase == PH_IDLE || rec_base.phase == PH_TINY) begin
					// A closing valley reports the cycle and opens the next one.
					emit              = (rec_base.phase == PH_TINY);
					rec_d             = '0;
					rec_d.phase       = PH_OPEN;
					rec_d.open_valley = item_s1.sample_index;
				end else begin
					rec_d = '0;
				end
			end
			LBL_NEAR_ZERO: begin
				if (rec_base.phase == PH_PEAK) begin
					if (rec_base.held_near_zero_first == '0 &&
					    rec_base.held_near_zero_last == '0) begin
						rec_d.held_near_zero_first = item_s1.sample_index;
					end else if (rec_base.held_near_zero_first != '0) begin
						rec_d.held_near_zero_last = item_s1.sample_index;
					end
				end
			end
			LBL_NONE: begin
				rec_d = rec_base;
			end
			default: begin
				rec_d = rec_base;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (s1_adv) begin
			rec_q <= rec_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv) begin
			res_valid_q <= emit;
		end else if (m_axis_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			res_q <= res_d;
		end
	end

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, res_q};

	// A result can only come out of a cycle that has seen its tiny peak.
	`ASSERT_IMPL(a_emit_phase, clk, arst_n, s1_adv && emit, rec_q.phase == PH_TINY && !item_s1.batch_start, "result emitted outside the closing phase")
	// The closing valley opens the next cycle.
	`ASSERT_NEXT(a_emit_reopens, clk, arst_n, s1_adv && emit, rec_q.phase == PH_OPEN, "cycle not reopened after a result")
	// A held sample waiting on the output side is not lost.
	`ASSERT_NEXT(a_s1_hold, clk, arst_n, valid_s1 && !s1_adv, valid_s1 && $stable(item_s1), "input stage lost a waiting sample")
	// The last near-zero index is only filled once the first one is.
	`ASSERT_CLK(a_nz_order, clk, arst_n, rec_q.held_near_zero_last == '0 || rec_q.held_near_zero_first != '0, "near-zero last set without first")

endmodule

`default_nettype wire
